// File: hw/rtl/gtdm_pkg.sv
// ----------------------------------------------------------------------------
// Gas transport delay measurement - shared definitions
// Field widths, sequencer states, phase codes, register indexes, command codes and reset values.
// ----------------------------------------------------------------------------
package gtdm_pkg;

   // Field widths
   localparam int TimeW  = 32;
   localparam int LevelW = 14;
   localparam int FlowW  = 16;
   localparam int SpW    = 10;
   localparam int CntW   = 8;
   localparam int CsrW   = 16;
   localparam int AddrW  = 3;
   localparam int InW    = 64;
   localparam int OutW   = 96;

   // Phase codes reported in the result word
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_RESET  = 3'd1,
      PH_PURGE  = 3'd2,
      PH_SETTLE = 3'd3,
      PH_TRACK  = 3'd4,
      PH_FLOW   = 3'd5,
      PH_DROP   = 3'd6
   } phase_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ELAPSED,
      ST_PHASE,
      ST_DELAY,
      ST_SUM,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Register indexes
   localparam logic [AddrW-1:0] REG_PURGE_TIME  = 3'd0;
   localparam logic [AddrW-1:0] REG_PUMP_SETTLE = 3'd1;
   localparam logic [AddrW-1:0] REG_LVL_SETTLE  = 3'd2;
   localparam logic [AddrW-1:0] REG_TARGET      = 3'd3;
   localparam logic [AddrW-1:0] REG_FLOW_THR    = 3'd4;
   localparam logic [AddrW-1:0] REG_DROP_THR    = 3'd5;
   localparam logic [AddrW-1:0] REG_AIR_SP      = 3'd6;
   localparam logic [AddrW-1:0] REG_N2_SP       = 3'd7;

   // Command codes carried in tuser
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Reset values
   localparam logic [15:0]       PURGE_TIME_RST  = 16'd15000;
   localparam logic [15:0]       PUMP_SETTLE_RST = 16'd20000;
   localparam logic [15:0]       LVL_SETTLE_RST  = 16'd10000;
   localparam logic [CntW-1:0]   TARGET_RST      = 8'd5;
   localparam logic [LevelW-1:0] FLOW_THR_RST    = 14'd50;
   localparam logic [LevelW-1:0] DROP_THR_RST    = 14'd150;
   localparam logic [SpW-1:0]    AIR_SP_RST      = 10'd500;
   localparam logic [SpW-1:0]    N2_SP_RST       = 10'd450;
   localparam logic [LevelW-1:0] MIN_LEVEL_RST   = 14'd10000;
   localparam logic [LevelW-1:0] MAX_LEVEL_RST   = 14'd0;
   localparam logic [FlowW-1:0]  PEAK_FLOW_RST   = 16'hD8F0; // minus 10000

endpackage

// File: hw/rtl/gas_transport_delay_measurement.sv
// ----------------------------------------------------------------------------
// Gas transport delay measurement sequencer
// Runs purge, pump settle, level tracking, nitrogen step and arrival timing,
// then reports the truncated mean delay over a run of samples.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one word per command. req_tuser is the command (start or sample),
//           req_tdata carries the timestamp, gas level and flow reading.
//   rsp_* : exactly one result word per accepted command word.
//   csr_* : register writes, taken at any edge with csr_we high; write only
//           while no command is in progress.
// Sequence: a word runs through a sequencer that shares one 33-bit adder for
//   time differences, limit compares, the delay sum and a restoring division.
//   A start word goes from the accept state straight to ST_FINISH; a sample
//   passes ST_ELAPSED and ST_PHASE for each chained phase, adds ST_DELAY and
//   ST_SUM when it books an arrival, and adds the 32-step division of the
//   delay sum when it ends a run, before ST_FINISH loads the output register.
// Throughput: one word at a time; req_tready is high only while the
//   sequencer is idle.
// Reset: synchronous; registers return to their defaults, phase goes idle.
// Stall: a finished result waits in the output register; the next word is
//   accepted meanwhile, and its own result waits until that one is taken.
// ----------------------------------------------------------------------------
module gas_transport_delay_measurement (
   input  logic                          clock,
   input  logic                          reset,
   // command stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [gtdm_pkg::InW-1:0]      req_tdata,  // now_ms[31:0], gas_level[45:32],
                                                     // flow_level[61:46], zero fill
   input  logic                          req_tuser,  // cmd[0]
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [gtdm_pkg::OutW-1:0]     rsp_tdata,  // phase[2:0], air_cmd_valid[3],
                                                     // air_setpoint[13:4], n2_cmd_valid[14],
                                                     // n2_setpoint[24:15], sample_done[25],
                                                     // sample_delay_ms[57:26], run_done[58],
                                                     // mean_delay_ms[90:59], zero fill
   // register writes
   input  logic                          csr_we,
   input  logic [gtdm_pkg::AddrW-1:0]    csr_addr,
   input  logic [gtdm_pkg::CsrW-1:0]     csr_wdata
);

   localparam int TW = gtdm_pkg::TimeW;
   localparam int LW = gtdm_pkg::LevelW;
   localparam int FW = gtdm_pkg::FlowW;
   localparam int SW = gtdm_pkg::SpW;
   localparam int CW = gtdm_pkg::CntW;

   // Configuration registers
   logic [15:0]   purge_time_ff, purge_time_in;
   logic [15:0]   pump_settle_ff, pump_settle_in;
   logic [15:0]   lvl_settle_ff, lvl_settle_in;
   logic [CW-1:0] target_ff, target_in;
   logic [LW-1:0] flow_thr_ff, flow_thr_in;
   logic [LW-1:0] drop_thr_ff, drop_thr_in;
   logic [SW-1:0] air_cfg_ff, air_cfg_in;
   logic [SW-1:0] n2_cfg_ff, n2_cfg_in;

   // Sequencer and measurement state
   gtdm_pkg::state_type state_ff, state_in;
   gtdm_pkg::phase_type phase_ff, phase_in;
   logic [LW-1:0]        min_level_ff, min_level_in;
   logic [LW-1:0]        max_level_ff, max_level_in;
   logic signed [FW-1:0] peak_flow_ff, peak_flow_in;
   logic [TW-1:0]        mark_ff, mark_in;
   logic [TW-1:0]        step_ff, step_in;
   logic [CW-1:0]        samples_ff, samples_in;
   logic [TW-1:0]        sum_ff, sum_in;

   // Latched command word
   logic                 cmd_ff, cmd_in;
   logic [TW-1:0]        now_ff, now_in;
   logic [LW-1:0]        level_ff, level_in;
   logic signed [FW-1:0] flow_ff, flow_in;

   // Working result and arithmetic registers
   logic [TW-1:0] elapsed_ff, elapsed_in;
   logic          air_v_ff, air_v_in;
   logic [SW-1:0] air_sp_ff, air_sp_in;
   logic          n2_v_ff, n2_v_in;
   logic [SW-1:0] n2_sp_ff, n2_sp_in;
   logic          s_done_ff, s_done_in;
   logic [TW-1:0] delay_ff, delay_in;
   logic          r_done_ff, r_done_in;
   logic [TW-1:0] quo_ff, quo_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [4:0]    bit_cnt_ff, bit_cnt_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [gtdm_pkg::OutW-1:0] rsp_data_ff, rsp_data_in;

   // Shared adder
   logic [TW-1:0] alu_a, alu_b;
   logic          alu_sub;
   logic [TW:0]   alu_sum;
   logic [TW-1:0] alu_res;
   logic          alu_co;

   // Helpers
   logic                 req_fire;
   logic [CW:0]          rem_shift;
   logic [CW-1:0]        divisor;
   logic [CW-1:0]        samples_inc;
   logic signed [FW+1:0] flow_goal;
   logic signed [LW:0]   drop_goal;
   logic [15:0]          phase_limit;
   logic [TW-1:0]        mean_out;

   assign req_tready = (state_ff == gtdm_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign divisor     = (target_ff == '0) ? CW'(1) : target_ff;
   assign rem_shift   = {rem_ff, quo_ff[TW-1]};
   assign samples_inc = samples_ff + CW'(1);
   assign flow_goal   = (FW+2)'(peak_flow_ff) + $signed({4'b0, flow_thr_ff});
   assign drop_goal   = $signed({1'b0, min_level_ff}) - $signed({1'b0, drop_thr_ff});
   assign mean_out    = r_done_ff ? quo_ff : '0;

   // Select the limit the current phase compares its elapsed time against
   always_comb begin
      case (phase_ff)
         gtdm_pkg::PH_PURGE:  phase_limit = purge_time_ff;
         gtdm_pkg::PH_SETTLE: phase_limit = pump_settle_ff;
         gtdm_pkg::PH_TRACK:  phase_limit = lvl_settle_ff;
         default:             phase_limit = '0;
      endcase
   end

   // Route operands to the shared adder
   always_comb begin
      case (state_ff)
         gtdm_pkg::ST_ELAPSED: begin
            alu_a = now_ff;     alu_b = mark_ff;           alu_sub = 1'b1;
         end
         gtdm_pkg::ST_PHASE: begin
            alu_a = elapsed_ff; alu_b = TW'(phase_limit);  alu_sub = 1'b1;
         end
         gtdm_pkg::ST_DELAY: begin
            alu_a = now_ff;     alu_b = step_ff;           alu_sub = 1'b1;
         end
         gtdm_pkg::ST_SUM: begin
            alu_a = sum_ff;     alu_b = delay_ff;          alu_sub = 1'b0;
         end
         gtdm_pkg::ST_DIV: begin
            alu_a = TW'(rem_shift); alu_b = TW'(divisor);  alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;         alu_b = '0;                alu_sub = 1'b0;
         end
      endcase
   end

   // Carry out of a subtraction means no borrow: a >= b
   assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b ^ {TW{alu_sub}}} + (TW+1)'(alu_sub);
   assign alu_res = alu_sum[TW-1:0];
   assign alu_co  = alu_sum[TW];

   // Register writes
   always_comb begin
      purge_time_in  = purge_time_ff;
      pump_settle_in = pump_settle_ff;
      lvl_settle_in  = lvl_settle_ff;
      target_in      = target_ff;
      flow_thr_in    = flow_thr_ff;
      drop_thr_in    = drop_thr_ff;
      air_cfg_in     = air_cfg_ff;
      n2_cfg_in      = n2_cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            gtdm_pkg::REG_PURGE_TIME:  purge_time_in  = csr_wdata;
            gtdm_pkg::REG_PUMP_SETTLE: pump_settle_in = csr_wdata;
            gtdm_pkg::REG_LVL_SETTLE:  lvl_settle_in  = csr_wdata;
            gtdm_pkg::REG_TARGET:      target_in      = csr_wdata[CW-1:0];
            gtdm_pkg::REG_FLOW_THR:    flow_thr_in    = csr_wdata[LW-1:0];
            gtdm_pkg::REG_DROP_THR:    drop_thr_in    = csr_wdata[LW-1:0];
            gtdm_pkg::REG_AIR_SP:      air_cfg_in     = csr_wdata[SW-1:0];
            gtdm_pkg::REG_N2_SP:       n2_cfg_in      = csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      min_level_in = min_level_ff;
      max_level_in = max_level_ff;
      peak_flow_in = peak_flow_ff;
      mark_in      = mark_ff;
      step_in      = step_ff;
      samples_in   = samples_ff;
      sum_in       = sum_ff;
      cmd_in       = cmd_ff;
      now_in       = now_ff;
      level_in     = level_ff;
      flow_in      = flow_ff;
      elapsed_in   = elapsed_ff;
      air_v_in     = air_v_ff;
      air_sp_in    = air_sp_ff;
      n2_v_in      = n2_v_ff;
      n2_sp_in     = n2_sp_ff;
      s_done_in    = s_done_ff;
      delay_in     = delay_ff;
      r_done_in    = r_done_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         // Take a command word and clear the working result
         gtdm_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_tuser;
               now_in    = req_tdata[TW-1:0];
               level_in  = req_tdata[TW+LW-1:TW];
               flow_in   = req_tdata[TW+LW+FW-1:TW+LW];
               air_v_in  = 1'b0;
               air_sp_in = '0;
               n2_v_in   = 1'b0;
               n2_sp_in  = '0;
               s_done_in = 1'b0;
               delay_in  = '0;
               r_done_in = 1'b0;
               if (req_tuser == gtdm_pkg::CMD_START) begin
                  samples_in = '0;
                  sum_in     = '0;
                  phase_in   = gtdm_pkg::PH_RESET;
                  state_in   = gtdm_pkg::ST_FINISH;
               end else begin
                  state_in = gtdm_pkg::ST_ELAPSED;
               end
            end
         end

         // Time since the last mark
         gtdm_pkg::ST_ELAPSED: begin
            elapsed_in = alu_res;
            state_in   = gtdm_pkg::ST_PHASE;
         end

         // Evaluate one phase; chained phases loop back through ST_ELAPSED
         gtdm_pkg::ST_PHASE: begin
            state_in = gtdm_pkg::ST_FINISH;
            case (phase_ff)
               gtdm_pkg::PH_RESET: begin
                  min_level_in = gtdm_pkg::MIN_LEVEL_RST;
                  max_level_in = gtdm_pkg::MAX_LEVEL_RST;
                  peak_flow_in = gtdm_pkg::PEAK_FLOW_RST;
                  mark_in      = now_ff;
                  air_v_in     = 1'b1;
                  air_sp_in    = air_cfg_ff;
                  phase_in     = gtdm_pkg::PH_PURGE;
                  state_in     = gtdm_pkg::ST_ELAPSED;
               end
               gtdm_pkg::PH_PURGE: begin
                  if (alu_co) begin
                     air_v_in  = 1'b1;
                     air_sp_in = '0;
                     mark_in   = now_ff;
                     phase_in  = gtdm_pkg::PH_SETTLE;
                     state_in  = gtdm_pkg::ST_ELAPSED;
                  end
               end
               gtdm_pkg::PH_SETTLE: begin
                  if (alu_co) begin
                     mark_in  = now_ff;
                     phase_in = gtdm_pkg::PH_TRACK;
                     state_in = gtdm_pkg::ST_ELAPSED;
                  end
               end
               gtdm_pkg::PH_TRACK: begin
                  if (flow_ff > peak_flow_ff) begin
                     peak_flow_in = flow_ff;
                  end
                  if (level_ff > max_level_ff) begin
                     max_level_in = level_ff;
                     mark_in      = now_ff;
                  end
                  if (level_ff < min_level_ff) begin
                     min_level_in = level_ff;
                     mark_in      = now_ff;
                  end else if ((level_ff > max_level_ff) ? (lvl_settle_ff == '0) : alu_co)
                  begin
                     // a new maximum restarts the steady time from zero
                     n2_v_in  = 1'b1;
                     n2_sp_in = n2_cfg_ff;
                     phase_in = gtdm_pkg::PH_FLOW;
                  end
               end
               gtdm_pkg::PH_FLOW: begin
                  if ((FW+2)'(flow_ff) >= flow_goal) begin
                     step_in  = now_ff;
                     phase_in = gtdm_pkg::PH_DROP;
                  end
               end
               gtdm_pkg::PH_DROP: begin
                  if ($signed({1'b0, level_ff}) <= drop_goal) begin
                     state_in = gtdm_pkg::ST_DELAY;
                  end
               end
               default: ;
            endcase
         end

         // Delay of this sample
         gtdm_pkg::ST_DELAY: begin
            delay_in = alu_res;
            state_in = gtdm_pkg::ST_SUM;
         end

         // Accumulate, count, and start the division on the last sample
         gtdm_pkg::ST_SUM: begin
            sum_in     = alu_res;
            n2_v_in    = 1'b1;
            n2_sp_in   = '0;
            s_done_in  = 1'b1;
            samples_in = samples_inc;
            if (samples_inc < target_ff) begin
               phase_in = gtdm_pkg::PH_RESET;
               state_in = gtdm_pkg::ST_FINISH;
            end else begin
               phase_in   = gtdm_pkg::PH_IDLE;
               r_done_in  = 1'b1;
               quo_in     = alu_res;
               rem_in     = '0;
               bit_cnt_in = '1;
               state_in   = gtdm_pkg::ST_DIV;
            end
         end

         // Restoring division, one quotient bit a cycle
         gtdm_pkg::ST_DIV: begin
            quo_in     = {quo_ff[TW-2:0], alu_co};
            rem_in     = alu_co ? alu_res[CW-1:0] : rem_shift[CW-1:0];
            bit_cnt_in = bit_cnt_ff - 5'd1;
            if (bit_cnt_ff == '0) begin
               state_in = gtdm_pkg::ST_FINISH;
            end
         end

         // Hand the result to the output register once it is free
         gtdm_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, mean_out, r_done_ff, delay_ff, s_done_ff,
                               n2_sp_ff, n2_v_ff, air_sp_ff, air_v_ff, phase_in};
               state_in     = gtdm_pkg::ST_IDLE;
            end
         end

         default: state_in = gtdm_pkg::ST_IDLE;
      endcase
   end

   // Control and measurement state
   always_ff @(posedge clock) begin
      if (reset) begin
         purge_time_ff  <= gtdm_pkg::PURGE_TIME_RST;
         pump_settle_ff <= gtdm_pkg::PUMP_SETTLE_RST;
         lvl_settle_ff  <= gtdm_pkg::LVL_SETTLE_RST;
         target_ff      <= gtdm_pkg::TARGET_RST;
         flow_thr_ff    <= gtdm_pkg::FLOW_THR_RST;
         drop_thr_ff    <= gtdm_pkg::DROP_THR_RST;
         air_cfg_ff     <= gtdm_pkg::AIR_SP_RST;
         n2_cfg_ff      <= gtdm_pkg::N2_SP_RST;
         state_ff       <= gtdm_pkg::ST_IDLE;
         phase_ff       <= gtdm_pkg::PH_IDLE;
         min_level_ff   <= gtdm_pkg::MIN_LEVEL_RST;
         max_level_ff   <= gtdm_pkg::MAX_LEVEL_RST;
         peak_flow_ff   <= gtdm_pkg::PEAK_FLOW_RST;
         mark_ff        <= '0;
         step_ff        <= '0;
         samples_ff     <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         purge_time_ff  <= purge_time_in;
         pump_settle_ff <= pump_settle_in;
         lvl_settle_ff  <= lvl_settle_in;
         target_ff      <= target_in;
         flow_thr_ff    <= flow_thr_in;
         drop_thr_ff    <= drop_thr_in;
         air_cfg_ff     <= air_cfg_in;
         n2_cfg_ff      <= n2_cfg_in;
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         min_level_ff   <= min_level_in;
         max_level_ff   <= max_level_in;
         peak_flow_ff   <= peak_flow_in;
         mark_ff        <= mark_in;
         step_ff        <= step_in;
         samples_ff     <= samples_in;
         sum_ff         <= sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      level_ff    <= level_in;
      flow_ff     <= flow_in;
      elapsed_ff  <= elapsed_in;
      air_v_ff    <= air_v_in;
      air_sp_ff   <= air_sp_in;
      n2_v_ff     <= n2_v_in;
      n2_sp_ff    <= n2_sp_in;
      s_done_ff   <= s_done_in;
      delay_ff    <= delay_in;
      r_done_ff   <= r_done_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // A start word never enters the phase arithmetic
   a_start_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gtdm_pkg::ST_ELAPSED) |-> (cmd_ff == gtdm_pkg::CMD_SAMPLE))
      else $error("start word reached the phase evaluation");

   // The division only runs for the word that ends a run
   a_div_run_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gtdm_pkg::ST_DIV) |-> (r_done_ff && s_done_ff))
      else $error("division running without a completed run");

   // A finished run reports a completed sample and returns to idle
   a_run_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[58]) |->
         (rsp_data_ff[25] && (rsp_data_ff[2:0] == gtdm_pkg::PH_IDLE)))
      else $error("run done without sample done or idle phase");

   // The sequencer is busy the cycle after it takes a word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("sequencer ready straight after accepting a word");

endmodule

// File: bench/gas_transport_delay_measurement_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gas transport delay measurement - testbench
// Drives start and sample words through the sequencer while both stream sides
// idle at random; every result word is checked against a hand-written one or
// a cycle-free model of purge, settle, track, nitrogen step and arrival timing.
// ----------------------------------------------------------------------------
module gas_transport_delay_measurement_tb;

   // Result word as it sits on rsp_tdata, lowest field last
   typedef struct packed {
      logic [4:0]  fill;
      logic [31:0] mean_delay;
      logic        run_done;
      logic [31:0] sample_delay;
      logic        sample_done;
      logic [9:0]  n2_sp;
      logic        n2_v;
      logic [9:0]  air_sp;
      logic        air_v;
      logic [2:0]  phase;
   } report_type;

   // One row of the directed table: a register write or a command word,
   // optionally with the result written out by hand
   typedef struct packed {
      logic        is_cfg;
      logic [2:0]  reg_idx;
      logic [15:0] reg_val;
      logic        cmd;
      logic [31:0] now;
      logic [13:0] level;
      logic [15:0] flow;
      logic        typed;
      logic [2:0]  t_phase;
      logic        t_air_v;
      logic [9:0]  t_air_sp;
   } stim_row_type;

   localparam int NUM_ROWS = 35;
   localparam int NUM_SETS = 12;
   localparam int SET_ITEMS = 160;

   // Walk the phases under the default registers, then chain the timed phases in
   // one word with zero times and a zero target, then make arrival impossible
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b1, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_START, 32'hFFFFFFFF, 14'h3FFF, 16'h8000,
        1'b1, gtdm_pkg::PH_RESET, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'hFFFFFF00, 14'd5000, 16'd0,
        1'b1, gtdm_pkg::PH_PURGE, 1'b1, 10'd500},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd14744, 14'h3FFF, 16'h7FFF,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd34744, 14'd5000, 16'd100,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd44744, 14'd5000, 16'd100,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd44764, 14'd5000, 16'd149,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd44784, 14'd5000, 16'd150,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd45000, 14'd4851, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd46018, 14'd4850, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_START, 32'd46100, 14'd0, 16'd0,
        1'b1, gtdm_pkg::PH_RESET, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_PURGE_TIME, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_PUMP_SETTLE, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_LVL_SETTLE, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_TARGET, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_FLOW_THR, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_DROP_THR, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_AIR_SP, 16'd1023, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_N2_SP, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_START, 32'd50, 14'd0, 16'd0,
        1'b1, gtdm_pkg::PH_RESET, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd100, 14'd0, 16'h8000,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd101, 14'd0, 16'h8000,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd102, 14'd0, 16'h8000,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd103, 14'd0, 16'hD8F0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd200, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd300, 14'd0, 16'd0,
        1'b1, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_DROP_THR, 16'h3FFF, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_TARGET, 16'd255, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_N2_SP, 16'd1023, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b1, gtdm_pkg::REG_FLOW_THR, 16'h3FFF, gtdm_pkg::CMD_SAMPLE, 32'd0, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_START, 32'd400, 14'd0, 16'd0,
        1'b1, gtdm_pkg::PH_RESET, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'hFFFFFFF0, 14'h3FFF, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'hFFFFFFF8, 14'h3FFF, 16'h7FFF,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_SAMPLE, 32'd5, 14'd0, 16'd0,
        1'b0, gtdm_pkg::PH_IDLE, 1'b0, 10'd0},
      '{1'b0, 3'd0, 16'd0, gtdm_pkg::CMD_START, 32'd9, 14'd0, 16'd0,
        1'b1, gtdm_pkg::PH_RESET, 1'b0, 10'd0}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [gtdm_pkg::InW-1:0]      req_tdata = '0;
   logic                          req_tuser = 1'b0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [gtdm_pkg::OutW-1:0]     rsp_tdata;
   logic                          csr_we = 1'b0;
   logic [gtdm_pkg::AddrW-1:0]    csr_addr = '0;
   logic [gtdm_pkg::CsrW-1:0]     csr_wdata = '0;

   // Shadow registers
   logic [15:0]       cfg_purge;
   logic [15:0]       cfg_pump;
   logic [15:0]       cfg_lvl_settle;
   logic [7:0]        cfg_target;
   logic [13:0]       cfg_flow_thr;
   logic [13:0]       cfg_drop_thr;
   logic [9:0]        cfg_air_sp;
   logic [9:0]        cfg_n2_sp;

   // Shadow sequencer state
   gtdm_pkg::phase_type sq_phase;
   int                lvl_min;
   int                lvl_max;
   int                flow_peak;
   logic [31:0]       t_mark;
   logic [31:0]       t_step;
   logic [7:0]        n_done;
   logic [31:0]       dly_sum;

   report_type        reports_due [$];
   int                n_bad = 0;
   int                burst_left = 0;
   bit                tx_on = 1'b0;
   logic [15:0]       rx_count = '0;
   logic [1:0]        rx_mode = '0;

   gas_transport_delay_measurement u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Receiver: switch at random between always ready, coin toss, one in four and
   // long stalls
   always @(posedge clock) begin
      rx_count <= rx_count + 16'd1;
      if (rx_count[6:0] == 7'd0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (rx_count[1:0] == 2'd0);
         default: rsp_tready <= (rx_count[4:0] == 5'd0);
      endcase
   end

   task automatic reset_shadow();
      cfg_purge      = gtdm_pkg::PURGE_TIME_RST;
      cfg_pump       = gtdm_pkg::PUMP_SETTLE_RST;
      cfg_lvl_settle = gtdm_pkg::LVL_SETTLE_RST;
      cfg_target     = gtdm_pkg::TARGET_RST;
      cfg_flow_thr   = gtdm_pkg::FLOW_THR_RST;
      cfg_drop_thr   = gtdm_pkg::DROP_THR_RST;
      cfg_air_sp     = gtdm_pkg::AIR_SP_RST;
      cfg_n2_sp      = gtdm_pkg::N2_SP_RST;
      sq_phase       = gtdm_pkg::PH_IDLE;
      lvl_min        = 10000;
      lvl_max        = 0;
      flow_peak      = -10000;
      t_mark         = '0;
      t_step         = '0;
      n_done         = '0;
      dly_sum        = '0;
   endtask

   // Advance the shadow sequencer by one command word and return its result
   function automatic report_type advance_sequencer(input logic cmd, input logic [31:0] now,
                                                    input logic [13:0] level,
                                                    input logic [15:0] flow_bits);
      report_type  r;
      int          lv;
      int          fl;
      logic [31:0] d;
      r  = '0;
      lv = int'(level);
      fl = int'($signed(flow_bits));
      if (cmd == gtdm_pkg::CMD_START) begin
         n_done   = '0;
         dly_sum  = '0;
         sq_phase = gtdm_pkg::PH_RESET;
      end else begin
         // arm a new sample and open the purge
         if (sq_phase == gtdm_pkg::PH_RESET) begin
            lvl_min   = 10000;
            lvl_max   = 0;
            flow_peak = -10000;
            t_mark    = now;
            r.air_v   = 1'b1;
            r.air_sp  = cfg_air_sp;
            sq_phase  = gtdm_pkg::PH_PURGE;
         end
         if (sq_phase == gtdm_pkg::PH_PURGE && (now - t_mark) >= 32'(cfg_purge)) begin
            r.air_v  = 1'b1;
            r.air_sp = '0;
            t_mark   = now;
            sq_phase = gtdm_pkg::PH_SETTLE;
         end
         if (sq_phase == gtdm_pkg::PH_SETTLE && (now - t_mark) >= 32'(cfg_pump)) begin
            t_mark   = now;
            sq_phase = gtdm_pkg::PH_TRACK;
         end
         // track extremes until the level holds still, then step nitrogen
         if (sq_phase == gtdm_pkg::PH_TRACK) begin
            if (fl > flow_peak) flow_peak = fl;
            if (lv > lvl_max) begin
               lvl_max = lv;
               t_mark  = now;
            end
            if (lv < lvl_min) begin
               lvl_min = lv;
               t_mark  = now;
            end else if ((now - t_mark) >= 32'(cfg_lvl_settle)) begin
               r.n2_v   = 1'b1;
               r.n2_sp  = cfg_n2_sp;
               sq_phase = gtdm_pkg::PH_FLOW;
            end
         end else if (sq_phase == gtdm_pkg::PH_FLOW) begin
            if (fl >= flow_peak + int'(cfg_flow_thr)) begin
               t_step   = now;
               sq_phase = gtdm_pkg::PH_DROP;
            end
         end else if (sq_phase == gtdm_pkg::PH_DROP) begin
            // arrival: close nitrogen, book the delay, maybe end the run
            if (lv <= lvl_min - int'(cfg_drop_thr)) begin
               d              = now - t_step;
               dly_sum        = dly_sum + d;
               r.n2_v         = 1'b1;
               r.n2_sp        = '0;
               r.sample_done  = 1'b1;
               r.sample_delay = d;
               n_done         = n_done + 8'd1;
               if (n_done < cfg_target) begin
                  sq_phase = gtdm_pkg::PH_RESET;
               end else begin
                  r.mean_delay = dly_sum / ((cfg_target == 8'd0) ? 32'd1 : 32'(cfg_target));
                  r.run_done   = 1'b1;
                  sq_phase     = gtdm_pkg::PH_IDLE;
               end
            end
         end
      end
      r.phase = sq_phase;
      return r;
   endfunction

   // Present one command word, hold it until taken, and book its result
   task automatic send_word(input logic cmd, input logic [31:0] now,
                            input logic [13:0] level, input logic [15:0] flow,
                            input bit typed, input report_type fixed);
      report_type calc;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, flow, level, now};
      tx_on = 1'b1;
      do @(negedge clock); while (!req_tready);
      calc = advance_sequencer(cmd, now, level, flow);
      reports_due.push_back(typed ? fixed : calc);
      @(posedge clock);
   endtask

   // Sender bursts: drop valid for a random gap once the burst runs out
   task automatic pace();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         tx_on = 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(0, 30);
      end
   endtask

   // Hold off until every booked result has come back and the block is quiet
   task automatic wait_idle();
      if (tx_on) begin
         req_tvalid <= 1'b0;
         tx_on = 1'b0;
      end
      while (reports_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         gtdm_pkg::REG_PURGE_TIME:  cfg_purge      = val;
         gtdm_pkg::REG_PUMP_SETTLE: cfg_pump       = val;
         gtdm_pkg::REG_LVL_SETTLE:  cfg_lvl_settle = val;
         gtdm_pkg::REG_TARGET:      cfg_target     = val[7:0];
         gtdm_pkg::REG_FLOW_THR:    cfg_flow_thr   = val[13:0];
         gtdm_pkg::REG_DROP_THR:    cfg_drop_thr   = val[13:0];
         gtdm_pkg::REG_AIR_SP:      cfg_air_sp     = val[9:0];
         default:                   cfg_n2_sp      = val[9:0];
      endcase
      @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         n_bad++;
      end
   endtask

   // Result checker: sample at the falling edge, ahead of the taking edge
   always @(negedge clock) begin : rsp_check
      report_type got;
      report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (reports_due.size() == 0) begin
            $error("result word %h arrived with nothing outstanding", rsp_tdata);
            n_bad++;
         end else begin
            want = reports_due.pop_front();
            compare_field("phase", 32'(want.phase), 32'(got.phase));
            compare_field("air_cmd_valid", 32'(want.air_v), 32'(got.air_v));
            compare_field("air_setpoint", 32'(want.air_sp), 32'(got.air_sp));
            compare_field("n2_cmd_valid", 32'(want.n2_v), 32'(got.n2_v));
            compare_field("n2_setpoint", 32'(want.n2_sp), 32'(got.n2_sp));
            compare_field("sample_done", 32'(want.sample_done), 32'(got.sample_done));
            compare_field("sample_delay_ms", want.sample_delay, got.sample_delay);
            compare_field("run_done", 32'(want.run_done), 32'(got.run_done));
            compare_field("mean_delay_ms", want.mean_delay, got.mean_delay);
         end
      end
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      stim_row_type row;
      report_type   fixed;
      bit          dirty;
      logic        cmd;
      logic [31:0] t;
      logic [15:0] v_purge, v_pump, v_lvl, v_target, v_fthr, v_dthr, v_air, v_n2;
      int          i, k, base, lv, fl, step_max;

      reset_shadow();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      dirty = 1'b0;
      for (i = 0; i < NUM_ROWS; i++) begin
         row = DIRECTED[i];
         if (row.is_cfg) begin
            if (dirty) wait_idle();
            dirty = 1'b0;
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            fixed          = '0;
            fixed.phase    = row.t_phase;
            fixed.air_v    = row.t_air_v;
            fixed.air_sp   = row.t_air_sp;
            send_word(row.cmd, row.now, row.level, row.flow, row.typed, fixed);
            pace();
            dirty = 1'b1;
         end
      end

      // Random sets: extremes high, all zero, then mostly short times
      for (k = 0; k < NUM_SETS; k++) begin
         wait_idle();
         if (k == 0) begin
            v_purge = 16'hFFFF; v_pump = 16'hFFFF; v_lvl = 16'hFFFF;
            v_target = 16'd255; v_fthr = 16'h3FFF; v_dthr = 16'h3FFF;
            v_air = 16'd1023; v_n2 = 16'd1023;
         end else if (k == 1) begin
            v_purge = '0; v_pump = '0; v_lvl = '0; v_target = '0;
            v_fthr = '0; v_dthr = '0; v_air = '0; v_n2 = '0;
         end else begin
            v_purge = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            v_pump  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            v_lvl   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
            case ($urandom_range(0, 7))
               0:       v_target = 16'd0;
               1:       v_target = 16'd255;
               default: v_target = 16'($urandom_range(1, 4));
            endcase
            v_fthr = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 16383))
                                                 : 16'($urandom_range(0, 200));
            v_dthr = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 16383))
                                                 : 16'($urandom_range(0, 200));
            v_air  = 16'($urandom_range(0, 1023));
            v_n2   = 16'($urandom_range(0, 1023));
         end
         write_reg(gtdm_pkg::REG_PURGE_TIME, v_purge);
         write_reg(gtdm_pkg::REG_PUMP_SETTLE, v_pump);
         write_reg(gtdm_pkg::REG_LVL_SETTLE, v_lvl);
         write_reg(gtdm_pkg::REG_TARGET, v_target);
         write_reg(gtdm_pkg::REG_FLOW_THR, v_fthr);
         write_reg(gtdm_pkg::REG_DROP_THR, v_dthr);
         write_reg(gtdm_pkg::REG_AIR_SP, v_air);
         write_reg(gtdm_pkg::REG_N2_SP, v_n2);

         // time steps scale with the longest wait so phases do move on
         step_max = int'(cfg_purge);
         if (int'(cfg_pump) > step_max) step_max = int'(cfg_pump);
         if (int'(cfg_lvl_settle) > step_max) step_max = int'(cfg_lvl_settle);
         step_max = step_max / 4 + 1;
         t    = $urandom;
         base = $urandom_range(200, 16000);

         for (i = 0; i < SET_ITEMS; i++) begin
            // mostly well-formed runs; a stray start now and then
            if (sq_phase == gtdm_pkg::PH_IDLE)
               cmd = ($urandom_range(0, 9) != 0) ? gtdm_pkg::CMD_START : gtdm_pkg::CMD_SAMPLE;
            else
               cmd = ($urandom_range(0, 49) == 0) ? gtdm_pkg::CMD_START : gtdm_pkg::CMD_SAMPLE;
            if (cmd == gtdm_pkg::CMD_START) base = $urandom_range(200, 16000);
            t = t + 32'($urandom_range(0, step_max));
            if ($urandom_range(0, 63) == 0) t = t + $urandom;
            lv = base + int'($urandom_range(0, 3));
            fl = int'($urandom_range(0, 400)) - 200;
            // push the waiting phases over their thresholds a third of the time
            if (sq_phase == gtdm_pkg::PH_FLOW && $urandom_range(0, 2) == 0)
               fl = flow_peak + int'(cfg_flow_thr) + int'($urandom_range(0, 20));
            if (sq_phase == gtdm_pkg::PH_DROP && $urandom_range(0, 2) == 0)
               lv = lvl_min - int'(cfg_drop_thr) - int'($urandom_range(0, 20));
            if ($urandom_range(0, 15) == 0) begin
               lv = int'($urandom_range(0, 16383));
               fl = int'($urandom_range(0, 65535)) - 32768;
            end
            if (lv < 0) lv = 0;
            if (lv > 16383) lv = 16383;
            if (fl < -32768) fl = -32768;
            if (fl > 32767) fl = 32767;
            send_word(cmd, t, 14'(lv), 16'(fl), 1'b0, '0);
            pace();
         end
      end

      wait_idle();
      if (n_bad == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
